@@ src/i2cmbe_pkg.sv @@
// Package for the I2C master byte engine: opcodes, command kinds,
// request and result payload types. No dependencies.
package i2cmbe_pkg;

  // Opcodes of an input request
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Wait lengths in delay units
  localparam logic [2:0] UNITS_1 = 3'd1;
  localparam logic [2:0] UNITS_2 = 3'd2;
  localparam logic [2:0] UNITS_3 = 3'd3;
  localparam logic [2:0] UNITS_5 = 3'd5;

  // Sequence in progress, one-hot
  typedef enum logic [4:0] {
    KIND_IDLE  = 5'b00001,
    KIND_START = 5'b00010,
    KIND_STOP  = 5'b00100,
    KIND_WRITE = 5'b01000,
    KIND_READ  = 5'b10000
  } kind_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } in_req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_ok;
    logic       rejected;
  } out_res_t;

endpackage

@@ src/i2c_master_byte_engine_top.sv @@
// I2C master byte engine top level: sequencer, pin state and output skid.
// Depends on i2cmbe_pkg.
//
// Usage: every input request is either a tick (one time unit) or a command
// (start, stop, write byte, read byte). A command is taken only while no
// sequence runs; one given while busy is dropped and flagged as rejected.
// Each request yields exactly one result carrying the SCL/SDA drives, busy,
// done, the last read byte, the last ACK status and the reject flag.
// Waits between pin actions are counted in ticks: units times time_scale,
// with a scale of zero acting as one.
// Config: write time_scale on the cfg channel (cfg_ready is always high)
// only while no request is in flight.
// Throughput: one request per clock while in_stall is low. The result is
// registered in the output register (or the skid register if it is held);
// the whole sequencer update is one pass of logic between the state registers.
// Stall: the output register is backed by a one-entry skid register, so a
// request is still taken in the cycle the receiver first stalls; in_stall
// rises once the skid entry is occupied and drops when it drains.
// Reset (rst_n low, synchronous): idle, both lines released, scale 1,
// no result pending.
module i2c_master_byte_engine_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cmbe_pkg::in_req_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cmbe_pkg::out_res_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import i2cmbe_pkg::*;

  // State registers
  logic [7:0]  scale_r;
  kind_t       kind_r, kind_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [10:0] wait_r, wait_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_st_r, ack_st_nxt;
  logic        ack_tx_r, ack_tx_nxt;

  // Output and skid registers
  logic        out_valid_r;
  out_res_t    out_r;
  logic        skid_valid_r;
  out_res_t    skid_r;

  logic        in_fire;
  logic        is_cmd;
  logic        run;
  logic        load;
  logic        done;
  logic        rej;
  logic [2:0]  units;
  logic [7:0]  scale_eff;
  logic [10:0] wait_dec;
  out_res_t    res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign is_cmd    = (in_data.opcode == OP_START) || (in_data.opcode == OP_STOP) ||
                     (in_data.opcode == OP_WRITE) || (in_data.opcode == OP_READ);
  assign scale_eff = (scale_r == 8'd0) ? 8'd1 : scale_r;
  assign wait_dec  = (wait_r != 11'd0) ? (wait_r - 11'd1) : 11'd0;

  // Sequencer: take a command or count a tick, then run the current phase
  always_comb begin
    kind_nxt    = kind_r;
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    wait_nxt    = wait_r;
    shift_nxt   = shift_r;
    tx_nxt      = tx_r;
    rd_nxt      = rd_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_st_nxt  = ack_st_r;
    ack_tx_nxt  = ack_tx_r;
    run         = 1'b0;
    load        = 1'b0;
    done        = 1'b0;
    rej         = 1'b0;
    units       = UNITS_1;

    if (in_fire) begin
      if (is_cmd) begin
        if (kind_r != KIND_IDLE) begin
          rej = 1'b1;
        end else begin
          phase_nxt   = 4'd0;
          bit_cnt_nxt = 4'd0;
          run         = 1'b1;
          case (in_data.opcode)
            OP_START: kind_nxt = KIND_START;
            OP_STOP:  kind_nxt = KIND_STOP;
            OP_WRITE: begin
              kind_nxt = KIND_WRITE;
              tx_nxt   = in_data.write_byte;
            end
            default: begin
              kind_nxt   = KIND_READ;
              ack_tx_nxt = in_data.send_ack;
              shift_nxt  = 8'd0;
            end
          endcase
        end
      end else if (kind_r != KIND_IDLE) begin
        wait_nxt = wait_dec;
        run      = (wait_dec == 11'd0);
      end
    end

    // Pin action of the current phase
    if (run) begin
      load = 1'b1;
      case (kind_nxt)
        KIND_START: begin
          case (phase_nxt)
            4'd0: begin scl_nxt = 1'b1; units = UNITS_3; end
            4'd1: begin sda_nxt = 1'b1; units = UNITS_3; end
            4'd2: begin sda_nxt = 1'b0; units = UNITS_3; end
            4'd3: begin scl_nxt = 1'b0; units = UNITS_3; end
            default: begin load = 1'b0; done = 1'b1; end
          endcase
        end
        KIND_STOP: begin
          case (phase_nxt)
            4'd0: begin sda_nxt = 1'b0; units = UNITS_3; end
            4'd1: begin scl_nxt = 1'b1; units = UNITS_3; end
            4'd2: begin sda_nxt = 1'b1; units = UNITS_3; end
            default: begin load = 1'b0; done = 1'b1; end
          endcase
        end
        KIND_WRITE: begin
          case (phase_nxt)
            4'd0: begin
              sda_nxt = tx_nxt[3'd7 - bit_cnt_nxt[2:0]];
              units   = UNITS_3;
            end
            4'd1: begin scl_nxt = 1'b1; units = UNITS_5; end
            4'd2: begin
              scl_nxt     = 1'b0;
              bit_cnt_nxt = bit_cnt_nxt + 4'd1;
              units       = UNITS_5;
            end
            4'd3: begin sda_nxt = 1'b1; units = UNITS_3; end
            4'd4: begin scl_nxt = 1'b1; units = UNITS_3; end
            4'd5: begin ack_st_nxt = !in_data.sda_in; units = UNITS_2; end
            4'd6: begin scl_nxt = 1'b0; units = UNITS_5; end
            default: begin load = 1'b0; done = 1'b1; end
          endcase
        end
        KIND_READ: begin
          case (phase_nxt)
            4'd0: begin sda_nxt = 1'b1; units = UNITS_1; end
            4'd1: begin scl_nxt = 1'b1; units = UNITS_3; end
            4'd2: begin
              shift_nxt = {shift_nxt[6:0], in_data.sda_in};
              units     = UNITS_2;
            end
            4'd3: begin
              scl_nxt     = 1'b0;
              bit_cnt_nxt = bit_cnt_nxt + 4'd1;
              units       = UNITS_5;
            end
            4'd4: begin sda_nxt = !ack_tx_nxt; units = UNITS_1; end
            4'd5: begin scl_nxt = 1'b1; units = UNITS_5; end
            4'd6: begin scl_nxt = 1'b0; units = UNITS_5; end
            default: begin
              rd_nxt = shift_nxt;
              load   = 1'b0;
              done   = 1'b1;
            end
          endcase
        end
        default: begin load = 1'b0; done = 1'b1; end
      endcase

      // Next phase: bit loops return to their start until eight bits are done
      if (load) begin
        wait_nxt  = 11'(units) * 11'(scale_eff);
        phase_nxt = phase_nxt + 4'd1;
        if (kind_nxt == KIND_WRITE && phase_nxt == 4'd3 && bit_cnt_nxt < 4'd8) begin
          phase_nxt = 4'd0;
        end
        if (kind_nxt == KIND_READ && phase_nxt == 4'd4 && bit_cnt_nxt < 4'd8) begin
          phase_nxt = 4'd1;
        end
      end
      if (done) begin
        kind_nxt  = KIND_IDLE;
        phase_nxt = 4'd0;
      end
    end
  end

  // Assemble the result from the updated state
  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (kind_nxt != KIND_IDLE);
    res.done_res  = done;
    res.read_data = rd_nxt;
    res.ack_ok    = ack_st_nxt;
    res.rejected  = rej;
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= 8'd1;
      kind_r    <= KIND_IDLE;
      phase_r   <= 4'd0;
      bit_cnt_r <= 4'd0;
      wait_r    <= 11'd0;
      shift_r   <= 8'd0;
      tx_r      <= 8'd0;
      rd_r      <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      ack_st_r  <= 1'b0;
      ack_tx_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale_r <= cfg_data;
      end
      kind_r    <= kind_nxt;
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      wait_r    <= wait_nxt;
      shift_r   <= shift_nxt;
      tx_r      <= tx_nxt;
      rd_r      <= rd_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      ack_st_r  <= ack_st_nxt;
      ack_tx_r  <= ack_tx_nxt;
    end
  end

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (!out_stall) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_r && out_stall) begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end else begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied with empty output register");

  // A stalled output keeps its result while the skid is full
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && skid_valid_r) |=> (out_valid_r && $stable(out_r)))
    else $error("output result changed under stall");

  // Done and reject never meet, and done ends the sequence
  a_done_rej: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !(done && rej) && !(done && (kind_nxt != KIND_IDLE)))
    else $error("done overlaps reject or busy");

  // Idle sequencer sits at phase zero
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == KIND_IDLE) |-> (phase_r == 4'd0))
    else $error("idle with nonzero phase");

  // A rejected command leaves the sequencer untouched
  a_rej_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && rej) |=> ($stable(kind_r) && $stable(phase_r) && $stable(wait_r)))
    else $error("rejected command changed sequencer state");

endmodule
